[src/uvd_pkg.sv]
`timescale 1ns / 1ps
package uvd_pkg;

   localparam int DEPTH_DEFAULT       = 16;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   localparam int ACTION_W   = 3;
   localparam int VALUE_W    = 32;
   localparam int POSITION_W = 8;
   localparam int COUNT_W    = 5;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 40;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH_FRONT = 3'd0,
      ACT_PUSH_BACK  = 3'd1,
      ACT_POP_FRONT  = 3'd2,
      ACT_POP_BACK   = 3'd3,
      ACT_CONTAINS   = 3'd4,
      ACT_READ_POS   = 3'd5
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_READ,
      ST_DONE
   } state_type;

endpackage

[src/uvd_ram.sv]
`timescale 1ns / 1ps
module uvd_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/unique_value_deque_unit.sv]
`timescale 1ns / 1ps
// Bounded deque of distinct values held in a single-port-write, registered-read
// ring RAM. One request beat is worked at a time. Pops and other actions go
// from the execute state to the result state; a position read adds a read
// state. A push to a deque neither empty nor full, or a contains on a
// non-empty deque, walks the stored entries one RAM read per cycle looking for
// the value, ending early on a match. The RAM needs no clearing after reset.
// A finished result sits in the output register while the next request is taken.
module unique_value_deque_unit #(
   parameter int DEPTH       = uvd_pkg::DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = uvd_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // action[2:0], value[34:3], position[42:35], zero fill
   input  logic [uvd_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // read_value[31:0], found[32], accepted[33], entry_count[38:34], zero fill
   output logic [uvd_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import uvd_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = (VALUE_WIDTH < VALUE_W) ? VALUE_WIDTH : VALUE_W;

   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                             input logic [AW:0]   off);
      logic [AW:0] s;
      s = {1'b0, base} + off;
      if (s >= (AW+1)'(DEPTH)) begin
         s = s - (AW+1)'(DEPTH);
      end
      return s[AW-1:0];
   endfunction

   state_type             state_ff, state_in;
   logic [AW-1:0]         head_ff, head_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [AW-1:0]         idx_ff, idx_in;
   logic [ACTION_W-1:0]   action_ff;
   logic [SW-1:0]         value_ff;
   logic [POSITION_W-1:0] pos_ff;
   logic [SW-1:0]         res_value_ff, res_value_in;
   logic                  res_found_ff, res_found_in;
   logic                  res_acc_ff, res_acc_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [AW:0]           rd_off;
   logic [SW-1:0]         rd_data;
   logic [AW-1:0]         head_m1;
   logic [POSITION_W-1:0] pos_eff;
   logic [31:0]           pos_ext;
   logic [31:0]           pos_m1;
   logic [31:0]           count_ext;
   logic                  hit;
   logic                  last_entry;
   logic                  req_beat;

   assign req_beat   = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign head_m1    = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);
   assign pos_eff    = (pos_ff == '0) ? POSITION_W'(1) : pos_ff;
   assign pos_ext    = 32'(pos_eff);
   assign pos_m1     = pos_ext - 32'd1;
   assign count_ext  = 32'(count_ff);
   assign hit        = (rd_data == value_ff);
   assign last_entry = ((CW'(idx_ff) + CW'(1)) == count_ff);

   uvd_ram #(
      .DEPTH (DEPTH),
      .WIDTH (SW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (value_ff),
      .rd_addr (slot_of(head_ff, rd_off)),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         action_ff <= req_tdata[2:0];
         value_ff  <= req_tdata[3 +: SW];
         pos_ff    <= req_tdata[42:35];
      end
      idx_ff       <= idx_in;
      res_value_ff <= res_value_in;
      res_found_ff <= res_found_in;
      res_acc_ff   <= res_acc_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      res_value_in = res_value_ff;
      res_found_in = res_found_ff;
      res_acc_in   = res_acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = slot_of(head_ff, (AW+1)'(count_ff));
      rd_off       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            res_value_in = '0;
            res_found_in = 1'b0;
            res_acc_in   = 1'b0;
            idx_in       = '0;
            state_in     = ST_DONE;
            case (action_ff)
               ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                  if (count_ff == CW'(DEPTH)) begin
                     state_in = ST_DONE;
                  end else if (count_ff == '0) begin
                     wr_en      = 1'b1;
                     res_acc_in = 1'b1;
                     count_in   = count_ff + CW'(1);
                     if (action_ff == ACT_PUSH_FRONT) begin
                        wr_addr = head_m1;
                        head_in = head_m1;
                     end
                  end else begin
                     state_in = ST_SCAN;
                  end
               end
               ACT_POP_FRONT: begin
                  if (count_ff != '0) begin
                     head_in    = slot_of(head_ff, (AW+1)'(1));
                     count_in   = count_ff - CW'(1);
                     res_acc_in = 1'b1;
                  end
               end
               ACT_POP_BACK: begin
                  if (count_ff != '0) begin
                     count_in   = count_ff - CW'(1);
                     res_acc_in = 1'b1;
                  end
               end
               ACT_CONTAINS: begin
                  if (count_ff != '0) begin
                     state_in = ST_SCAN;
                  end
               end
               ACT_READ_POS: begin
                  if (pos_ext <= count_ext) begin
                     rd_off   = pos_m1[AW:0];
                     state_in = ST_READ;
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end

         ST_SCAN: begin
            rd_off = (AW+1)'(idx_ff) + (AW+1)'(1);
            idx_in = idx_ff + AW'(1);
            if (hit || last_entry) begin
               state_in = ST_DONE;
               if (action_ff == ACT_CONTAINS) begin
                  res_found_in = hit;
               end else if (!hit) begin
                  wr_en      = 1'b1;
                  res_acc_in = 1'b1;
                  count_in   = count_ff + CW'(1);
                  if (action_ff == ACT_PUSH_FRONT) begin
                     wr_addr = head_m1;
                     head_in = head_m1;
                  end
               end
            end
         end

         ST_READ: begin
            res_value_in = rd_data;
            res_found_in = 1'b1;
            state_in     = ST_DONE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, count_ext[4:0], res_acc_ff, res_found_ff,
                               32'(res_value_ff)};
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_write_grows: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> count_ff == $past(count_ff) + CW'(1))
      else $error("store write without count increment");

   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> CW'(idx_ff) < count_ff)
      else $error("scan past stored entries");

   a_beat_starts: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> state_ff == ST_EXEC)
      else $error("request beat did not start work");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;
   import uvd_pkg::*;

   localparam int DEPTH          = DEPTH_DEFAULT;
   localparam int VALUE_POOL     = 24;
   localparam int LONG_HOLD      = 200;
   localparam int SETTLE_CYCLES  = 2 * DEPTH + 10;
   localparam int WATCHDOG_LIMIT = 5000;

   localparam logic [ACTION_W-1:0] ACT_UNUSED_A = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_UNUSED_B = 3'd7;

   typedef struct packed {
      logic [VALUE_W-1:0] read_value;
      logic               found;
      logic               accepted;
      logic [COUNT_W-1:0] entry_count;
   } response_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // shadow copy of the deque
   logic [VALUE_W-1:0] shadow_ring [DEPTH];
   int                 shadow_head  = 0;
   int                 shadow_count = 0;

   response_type pending_responses [$];
   logic [VALUE_W-1:0] value_pool [VALUE_POOL];

   int  fail_count      = 0;
   int  beats_sent      = 0;
   int  beats_checked   = 0;
   int  pushes_stored   = 0;
   int  pushes_dup      = 0;
   int  pushes_full     = 0;
   int  empty_pops      = 0;
   int  lookup_hits     = 0;
   int  stall_cycles    = 0;
   bit  send_idle_on    = 1'b0;
   bit  rsp_idle_on     = 1'b0;
   bit  hold_request    = 1'b0;

   unique_value_deque_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int slot_at(int offset);
      return (shadow_head + offset) % DEPTH;
   endfunction

   function automatic bit shadow_holds(logic [VALUE_W-1:0] val);
      for (int k = 0; k < shadow_count; k++) begin
         if (shadow_ring[slot_at(k)] == val) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic response_type predict_response(logic [ACTION_W-1:0] act,
                                                     logic [VALUE_W-1:0] val,
                                                     logic [POSITION_W-1:0] pos);
      response_type rsp;
      int           index;
      rsp = '0;
      case (act)
         ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
            if (shadow_count >= DEPTH) begin
               pushes_full++;
            end else if (shadow_holds(val)) begin
               pushes_dup++;
            end else begin
               if (act == ACT_PUSH_FRONT) begin
                  shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                  shadow_ring[shadow_head] = val;
               end else begin
                  shadow_ring[slot_at(shadow_count)] = val;
               end
               shadow_count++;
               rsp.accepted = 1'b1;
               pushes_stored++;
            end
         end
         ACT_POP_FRONT, ACT_POP_BACK: begin
            if (shadow_count > 0) begin
               if (act == ACT_POP_FRONT) shadow_head = slot_at(1);
               shadow_count--;
               rsp.accepted = 1'b1;
            end else begin
               empty_pops++;
            end
         end
         ACT_CONTAINS: begin
            rsp.found = shadow_holds(val);
            if (rsp.found) lookup_hits++;
         end
         ACT_READ_POS: begin
            index = (pos == 0) ? 1 : int'(pos);
            if (index <= shadow_count) begin
               rsp.read_value = shadow_ring[slot_at(index - 1)];
               rsp.found = 1'b1;
               lookup_hits++;
            end
         end
         default: ;
      endcase
      rsp.entry_count = shadow_count[COUNT_W-1:0];
      return rsp;
   endfunction

   // result checker
   always @(posedge clock) begin
      response_type got;
      response_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.read_value  = rsp_tdata[31:0];
         got.found       = rsp_tdata[32];
         got.accepted    = rsp_tdata[33];
         got.entry_count = rsp_tdata[38:34];
         beats_checked++;
         if (pending_responses.size() == 0) begin
            $error("unexpected result beat: %h", rsp_tdata);
            fail_count++;
         end else begin
            want = pending_responses[0];
            pending_responses.delete(0);
            if (got.read_value !== want.read_value) begin
               $error("read_value mismatch: expected %h, actual %h",
                      want.read_value, got.read_value);
               fail_count++;
            end
            if (got.found !== want.found) begin
               $error("found mismatch: expected %0d, actual %0d", want.found, got.found);
               fail_count++;
            end
            if (got.accepted !== want.accepted) begin
               $error("accepted mismatch: expected %0d, actual %0d",
                      want.accepted, got.accepted);
               fail_count++;
            end
            if (got.entry_count !== want.entry_count) begin
               $error("entry_count mismatch: expected %0d, actual %0d",
                      want.entry_count, got.entry_count);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $error("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
         $display("FAIL");
         $finish;
      end
   end

   // result side ready generator
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (rsp_idle_on && $urandom_range(0, 6) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_item(logic [ACTION_W-1:0] act, logic [VALUE_W-1:0] val,
                            logic [POSITION_W-1:0] pos);
      if (send_idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, pos, val, act};
      do @(posedge clock); while (!req_tready);
      pending_responses.insert(pending_responses.size(), predict_response(act, val, pos));
      beats_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         7: return $urandom;
         8: return ($urandom_range(0, 1) != 0) ? {VALUE_W{1'b1}} : '0;
         9: begin
            if (shadow_count > 0)
               return shadow_ring[slot_at($urandom_range(0, shadow_count - 1))];
            return $urandom;
         end
         default: return value_pool[$urandom_range(0, VALUE_POOL - 1)];
      endcase
   endfunction

   function automatic logic [POSITION_W-1:0] pick_position();
      if ($urandom_range(0, 3) == 0) return POSITION_W'($urandom_range(0, 255));
      return POSITION_W'($urandom_range(0, shadow_count + 2));
   endfunction

   task automatic send_random_item();
      int                  roll;
      logic [ACTION_W-1:0] act;
      roll = $urandom_range(0, 99);
      if (roll < 22)      act = ACT_PUSH_FRONT;
      else if (roll < 44) act = ACT_PUSH_BACK;
      else if (roll < 56) act = ACT_POP_FRONT;
      else if (roll < 68) act = ACT_POP_BACK;
      else if (roll < 80) act = ACT_CONTAINS;
      else if (roll < 95) act = ACT_READ_POS;
      else                act = ($urandom_range(0, 1) != 0) ? ACT_UNUSED_A : ACT_UNUSED_B;
      send_item(act, pick_value(), pick_position());
   endtask

   task automatic test_directed_cases();
      send_item(ACT_READ_POS,   '0, 8'd0);
      send_item(ACT_POP_FRONT,  '0, 8'd0);
      send_item(ACT_POP_BACK,   '0, 8'd0);
      send_item(ACT_CONTAINS,   '0, 8'd0);
      send_item(ACT_PUSH_BACK,  '0, 8'd0);
      send_item(ACT_PUSH_BACK,  '0, 8'd0);
      send_item(ACT_PUSH_FRONT, 32'hFFFF_FFFF, 8'd255);
      send_item(ACT_CONTAINS,   32'hFFFF_FFFF, 8'd0);
      send_item(ACT_CONTAINS,   32'h1234_5678, 8'd0);
      send_item(ACT_READ_POS,   '0, 8'd0);
      send_item(ACT_READ_POS,   '0, 8'd1);
      send_item(ACT_READ_POS,   '0, 8'd2);
      send_item(ACT_READ_POS,   '0, 8'd3);
      send_item(ACT_READ_POS,   32'hFFFF_FFFF, 8'd255);
      send_item(ACT_UNUSED_A,   32'hDEAD_BEEF, 8'd1);
      send_item(ACT_UNUSED_B,   32'hFFFF_FFFF, 8'd255);
      send_item(ACT_POP_BACK,   '0, 8'd0);
      send_item(ACT_POP_FRONT,  '0, 8'd0);
      send_item(ACT_READ_POS,   '0, 8'd1);
      send_item(ACT_PUSH_FRONT, 32'hA5A5_A5A5, 8'd0);
      send_item(ACT_PUSH_BACK,  32'h5A5A_5A5A, 8'd0);
      send_item(ACT_POP_FRONT,  '0, 8'd0);
      send_item(ACT_POP_BACK,   '0, 8'd0);
      wait_drained();
   endtask

   task automatic test_fill_and_drain();
      int tries;
      tries = 0;
      while (shadow_count < DEPTH && tries < 4 * DEPTH) begin
         send_item(($urandom_range(0, 1) != 0) ? ACT_PUSH_FRONT : ACT_PUSH_BACK,
                   pick_value(), 8'd0);
         tries++;
      end
      send_item(ACT_PUSH_FRONT, $urandom, 8'd0);
      send_item(ACT_PUSH_BACK, pick_value(), 8'd0);
      for (int p = 0; p <= DEPTH + 1; p++) send_item(ACT_READ_POS, '0, p[POSITION_W-1:0]);
      send_item(ACT_CONTAINS, pick_value(), 8'd0);
      while (shadow_count > 0) begin
         send_item(($urandom_range(0, 1) != 0) ? ACT_POP_FRONT : ACT_POP_BACK,
                   '0, 8'd0);
      end
      send_item(ACT_POP_BACK, '0, 8'd0);
   endtask

   task automatic test_random_mix(int count, bit vary_idle = 1'b1);
      for (int n = 0; n < count; n++) begin
         if (vary_idle && n % 100 == 0) begin
            send_idle_on = ($urandom_range(0, 3) != 0);
            rsp_idle_on  = ($urandom_range(0, 3) != 0);
         end
         send_random_item();
      end
   endtask

   task automatic test_output_backpressure();
      hold_request = 1'b1;
      for (int n = 0; n < 24; n++) send_random_item();
   endtask

   task automatic test_pause_until_empty();
      test_random_mix(150);
      wait_drained();
      test_random_mix(150);
   endtask

   initial begin
      for (int k = 0; k < VALUE_POOL; k++) value_pool[k] = $urandom;
      for (int k = 0; k < DEPTH; k++) shadow_ring[k] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      send_idle_on = 1'b1;
      rsp_idle_on  = 1'b1;
      for (int r = 0; r < 3; r++) test_fill_and_drain();
      test_random_mix(500);
      test_output_backpressure();
      test_pause_until_empty();
      test_random_mix(400);
      test_fill_and_drain();
      send_idle_on = 1'b0;
      rsp_idle_on  = 1'b0;
      test_random_mix(300, 1'b0);

      wait_drained();
      if (pending_responses.size() != 0) begin
         $error("%0d results never arrived", pending_responses.size());
         fail_count++;
      end
      $display("Sent %0d request beats, checked %0d result beats; %0d pushes stored,",
               beats_sent, beats_checked, pushes_stored);
      $display("%0d duplicate and %0d full pushes refused, %0d empty pops, %0d lookup hits",
               pushes_dup, pushes_full, empty_pops, lookup_hits);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
